>>> rtl/core/esu_pkg.sv
// Shared types, codes and helpers for the expression stack unit.
package esu_pkg;

	// Stream payload widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Number of defined relation codes for compare.
	localparam int REL_COUNT = 6;

	// Operation codes carried in the op field.
	typedef enum logic [3:0] {
		OP_PUSH    = 4'd0,
		OP_ADD     = 4'd1,
		OP_SUB     = 4'd2,
		OP_NEG     = 4'd3,
		OP_MUL     = 4'd4,
		OP_DIV     = 4'd5,
		OP_STORE   = 4'd6,
		OP_INDEX   = 4'd7,
		OP_POP     = 4'd8,
		OP_COMPARE = 4'd9,
		OP_CLEAR   = 4'd10
	} op_t;

	// Status codes reported with every result.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNDER    = 3'd1,
		ST_OVER     = 3'd2,
		ST_DIVZERO  = 3'd3,
		ST_BADREL   = 3'd4,
		ST_BADINDEX = 3'd5
	} status_t;

	// Relation codes used by compare.
	typedef enum logic [2:0] {
		REL_EQ = 3'd0,
		REL_LT = 3'd1,
		REL_LE = 3'd2,
		REL_NE = 3'd3,
		REL_GT = 3'd4,
		REL_GE = 3'd5
	} rel_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_RDC,
		S_EXEC,
		S_MULDIV,
		S_TOPC,
		S_DONE
	} esu_state_t;

	// Phases of the shared multiply and divide unit.
	typedef enum logic [2:0] {
		P_IDLE,
		P_ABS_N,
		P_ABS_D,
		P_LOOP,
		P_FIX
	} md_phase_t;

	// Request from the sequencer to the multiply and divide unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} md_ctrl_t;

	// Status from the multiply and divide unit.
	typedef struct packed {
		logic done;
		logic busy;
	} md_stat_t;

	// Number of stack entries an operation consumes.
	function automatic logic [1:0] need_count(op_t op);
		logic [1:0] n;
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_STORE: n = 2'd2;
			OP_NEG, OP_INDEX, OP_POP:                 n = 2'd1;
			OP_COMPARE:                               n = 2'd3;
			default:                                  n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/core/esu_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring signed divide on one adder.
module esu_muldiv import esu_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  md_ctrl_t             ctrl,
	input  logic [WORD_BITS-1:0] num,
	input  logic [WORD_BITS-1:0] den,
	output md_stat_t             stat,
	output logic [WORD_BITS-1:0] result
);

	localparam int CW = $clog2(WORD_BITS);

	md_phase_t            phase_q, phase_d;
	logic                 done_q;
	logic                 is_div_q;
	logic                 neg_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] num_q;
	logic [WORD_BITS-1:0] den_q;
	logic [WORD_BITS-1:0] res_q;

	logic [WORD_BITS:0]   add_x;
	logic [WORD_BITS:0]   add_y;
	logic                 add_sub;
	logic [WORD_BITS:0]   sum;

	// Operand selection for the single shared adder.
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (phase_q)
			P_ABS_N: begin
				add_y   = {1'b0, num_q};
				add_sub = 1'b1;
			end
			P_ABS_D: begin
				add_y   = {1'b0, den_q};
				add_sub = 1'b1;
			end
			P_LOOP: begin
				if (is_div_q) begin
					add_x   = {acc_q, num_q[WORD_BITS-1]};
					add_y   = {1'b0, den_q};
					add_sub = 1'b1;
				end else begin
					add_x = {1'b0, acc_q};
					add_y = {1'b0, den_q};
				end
			end
			P_FIX: begin
				add_y   = {1'b0, num_q};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign sum = add_x + (add_sub ? ~add_y : add_y) + (WORD_BITS+1)'(add_sub);

	// Phase sequencing: magnitudes first for a divide, then one bit a cycle, then sign fix.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			P_IDLE: begin
				if (ctrl.start) begin
					phase_d = ctrl.is_div ? P_ABS_N : P_LOOP;
				end
			end
			P_ABS_N: phase_d = P_ABS_D;
			P_ABS_D: phase_d = P_LOOP;
			P_LOOP: begin
				if (cnt_q == '0) begin
					phase_d = P_FIX;
				end
			end
			P_FIX:   phase_d = P_IDLE;
			default: phase_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == P_FIX);
		end
	end

	// Working registers of the multiply and divide iterations.
	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (ctrl.start) begin
					num_q    <= num;
					den_q    <= den;
					acc_q    <= '0;
					is_div_q <= ctrl.is_div;
					neg_q    <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
					cnt_q    <= CW'(WORD_BITS - 1);
				end
			end
			P_ABS_N: begin
				if (num_q[WORD_BITS-1]) begin
					num_q <= sum[WORD_BITS-1:0];
				end
			end
			P_ABS_D: begin
				if (den_q[WORD_BITS-1]) begin
					den_q <= sum[WORD_BITS-1:0];
				end
			end
			P_LOOP: begin
				cnt_q <= cnt_q - CW'(1);
				if (is_div_q) begin
					// Restoring step: keep the difference when it is not negative.
					if (!sum[WORD_BITS]) begin
						acc_q <= sum[WORD_BITS-1:0];
					end else begin
						acc_q <= add_x[WORD_BITS-1:0];
					end
					num_q <= {num_q[WORD_BITS-2:0], ~sum[WORD_BITS]};
				end else begin
					if (num_q[0]) begin
						acc_q <= sum[WORD_BITS-1:0];
					end
					num_q <= num_q >> 1;
					den_q <= den_q << 1;
				end
			end
			P_FIX: begin
				if (is_div_q) begin
					res_q <= neg_q ? sum[WORD_BITS-1:0] : num_q;
				end else begin
					res_q <= acc_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign stat.done = done_q;
	assign stat.busy = (phase_q != P_IDLE);
	assign result    = res_q;

	// A new request only arrives while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> (phase_q == P_IDLE))
		else $error("multiply/divide started while busy");

	// The last iteration is always followed by the sign fix.
	a_loop_end: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_LOOP && cnt_q == '0) |=> (phase_q == P_FIX))
		else $error("iteration count did not end the loop");

	// The done pulse comes with the unit back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q == P_IDLE))
		else $error("done raised while unit still running");

endmodule

>>> rtl/core/expression_stack_unit.sv
// Top level: expression stack, variable store and the sequencer that drives the shared unit.
//
//  Channel  Dir  Handshake          Contents (lowest bit first)
//  s_*      in   s_tvalid/s_tready  op[3:0], value[35:4], clear_vars[36], zero fill to 40 bits
//  m_*      out  m_tvalid/m_tready  result[31:0], cond_true[32], status[35:33], zero fill to 40
//
// Every item passes S_RDA; add, sub, mul, div and store add S_RDB, compare adds S_RDB, S_RDC;
// then come S_EXEC and S_DONE, with S_TOPC between when a store or compare reads the new top.
// Multiply and divide wait in S_MULDIV between S_EXEC and S_DONE, paced by the one-bit-a-cycle
// shared unit. Stack operands come one a cycle through the single read port of the stack memory.
// Reset empties the stack and marks every variable as zero through per-entry valid bits.
// A finished result waits in the output register; only a second result stalls the sequencer.
module expression_stack_unit import esu_pkg::*; #(
	parameter int STACK_DEPTH    = 32,
	parameter int VARIABLE_COUNT = 26,
	parameter int WORD_BITS      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // op[3:0], value[35:4], clear_vars[36]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // result[31:0], cond_true[32], status[35:33]
);

	localparam int SA_W      = $clog2(STACK_DEPTH);
	localparam int STK_SLOTS = 1 << SA_W;
	localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int VIDX_W    = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
	localparam int VAR_SLOTS = 1 << VIDX_W;

	// Input fields.
	logic [3:0]           in_op;
	logic [31:0]          in_value;
	logic                 in_clear_vars;
	logic [63:0]          val_ext;
	logic                 accept;

	// Sequencer and item registers.
	esu_state_t           state_q, state_d;
	op_t                  op_q;
	logic [WORD_BITS-1:0] val_q;
	logic                 cv_q;
	logic                 under_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] c_q;

	// Result staging and output register.
	logic [WORD_BITS-1:0] res_q;
	logic                 cond_q;
	status_t              stat_q;
	logic [63:0]          res_wide;
	logic                 m_tvalid_q;
	logic [31:0]          out_res_q;
	logic                 out_cond_q;
	status_t              out_stat_q;

	// Stack memory.
	logic [WORD_BITS-1:0] stk_mem [STK_SLOTS];
	logic [WORD_BITS-1:0] stk_rd_q;
	logic                 stk_we;
	logic [SA_W-1:0]      stk_wa;
	logic [WORD_BITS-1:0] stk_wd;
	logic [SA_W-1:0]      stk_ra;

	// Variable store with per-entry valid bits.
	logic [WORD_BITS-1:0] var_mem [VAR_SLOTS];
	logic [VAR_SLOTS-1:0] var_vld_q;
	logic [WORD_BITS-1:0] var_rd_q;
	logic                 var_rdv_q;
	logic [VIDX_W-1:0]    var_ra;
	logic [VIDX_W-1:0]    var_wa;
	logic                 var_we;
	logic                 var_clr;

	// Decoded control from the sequencer.
	logic                 cnt_ld;
	logic [CNT_W-1:0]     cnt_d;
	logic                 res_ld;
	logic [WORD_BITS-1:0] res_d;
	logic                 info_ld;
	logic                 cond_d;
	logic                 out_ld;
	status_t              exec_stat;

	// Helpers for the operations done in the execute state.
	logic [CNT_W-1:0]     cnt_m1, cnt_m2, cnt_m3, cnt_m4;
	logic                 a_ok, b_ok, rel_ok;
	logic [WORD_BITS-1:0] as_x;
	logic                 as_sub;
	logic [WORD_BITS-1:0] as_sum;
	logic [WORD_BITS-1:0] var_val;
	logic [WORD_BITS-1:0] top_old;
	logic                 rel_hit;

	// Shared multiply and divide unit.
	md_ctrl_t             md_ctrl;
	md_stat_t             md_stat;
	logic [WORD_BITS-1:0] md_res;

	assign in_op         = s_tdata[3:0];
	assign in_value      = s_tdata[35:4];
	assign in_clear_vars = s_tdata[36];
	assign val_ext       = 64'($signed(in_value));

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);
	assign cnt_m3 = cnt_q - CNT_W'(3);
	assign cnt_m4 = cnt_q - CNT_W'(4);

	assign a_ok   = (a_q < WORD_BITS'(VARIABLE_COUNT));
	assign b_ok   = (b_q < WORD_BITS'(VARIABLE_COUNT));
	assign rel_ok = (b_q < WORD_BITS'(REL_COUNT));

	// One adder serves add, subtract and negate.
	assign as_x   = (op_q == OP_NEG) ? '0 : b_q;
	assign as_sub = (op_q != OP_ADD);
	assign as_sum = as_x + (as_sub ? ~a_q : a_q) + WORD_BITS'(as_sub);

	assign var_val = var_rdv_q ? var_rd_q : '0;
	assign top_old = (cnt_q != '0) ? a_q : '0;
	assign var_ra  = stk_rd_q[VIDX_W-1:0];
	assign var_wa  = b_q[VIDX_W-1:0];

	// Relation test on the signed left and right operands.
	always_comb begin
		case (rel_t'(b_q[2:0]))
			REL_EQ:  rel_hit = ($signed(c_q) == $signed(a_q));
			REL_LT:  rel_hit = ($signed(c_q) <  $signed(a_q));
			REL_LE:  rel_hit = ($signed(c_q) <= $signed(a_q));
			REL_NE:  rel_hit = ($signed(c_q) != $signed(a_q));
			REL_GT:  rel_hit = ($signed(c_q) >  $signed(a_q));
			REL_GE:  rel_hit = ($signed(c_q) >= $signed(a_q));
			default: rel_hit = 1'b0;
		endcase
	end

	// Checks made once all operands are in.
	always_comb begin
		if (under_q) begin
			exec_stat = ST_UNDER;
		end else begin
			case (op_q)
				OP_PUSH:    exec_stat = (cnt_q == CNT_W'(STACK_DEPTH)) ? ST_OVER : ST_OK;
				OP_DIV:     exec_stat = (a_q == '0) ? ST_DIVZERO : ST_OK;
				OP_STORE:   exec_stat = b_ok ? ST_OK : ST_BADINDEX;
				OP_INDEX:   exec_stat = a_ok ? ST_OK : ST_BADINDEX;
				OP_COMPARE: exec_stat = rel_ok ? ST_OK : ST_BADREL;
				default:    exec_stat = ST_OK;
			endcase
		end
	end

	// Sequencer: next state and datapath controls.
	always_comb begin
		state_d        = state_q;
		stk_we         = 1'b0;
		stk_wa         = cnt_m1[SA_W-1:0];
		stk_wd         = as_sum;
		stk_ra         = cnt_m1[SA_W-1:0];
		var_we         = 1'b0;
		var_clr        = 1'b0;
		cnt_ld         = 1'b0;
		cnt_d          = cnt_q;
		res_ld         = 1'b0;
		res_d          = top_old;
		info_ld        = 1'b0;
		cond_d         = 1'b0;
		out_ld         = 1'b0;
		md_ctrl.start  = 1'b0;
		md_ctrl.is_div = (op_q == OP_DIV);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				stk_ra = cnt_m2[SA_W-1:0];
				if (!under_q && need_count(op_q) >= 2'd2) begin
					state_d = S_RDB;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RDB: begin
				stk_ra = cnt_m3[SA_W-1:0];
				if (!under_q && op_q == OP_COMPARE) begin
					state_d = S_RDC;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RDC: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				info_ld = 1'b1;
				res_ld  = 1'b1;
				state_d = S_DONE;
				if (exec_stat == ST_OK) begin
					var_clr = cv_q;
					case (op_q)
						OP_PUSH: begin
							stk_we = 1'b1;
							stk_wa = cnt_q[SA_W-1:0];
							stk_wd = val_q;
							cnt_ld = 1'b1;
							cnt_d  = cnt_q + CNT_W'(1);
							res_d  = val_q;
						end
						OP_ADD, OP_SUB: begin
							stk_we = 1'b1;
							stk_wa = cnt_m2[SA_W-1:0];
							cnt_ld = 1'b1;
							cnt_d  = cnt_m1;
							res_d  = as_sum;
						end
						OP_NEG: begin
							stk_we = 1'b1;
							res_d  = as_sum;
						end
						OP_MUL, OP_DIV: begin
							md_ctrl.start = 1'b1;
							res_ld        = 1'b0;
							state_d       = S_MULDIV;
						end
						OP_STORE: begin
							var_we = 1'b1;
							cnt_ld = 1'b1;
							cnt_d  = cnt_m2;
							stk_ra = cnt_m3[SA_W-1:0];
							res_d  = '0;
							if (cnt_q > CNT_W'(2)) begin
								res_ld  = 1'b0;
								state_d = S_TOPC;
							end
						end
						OP_INDEX: begin
							stk_we = 1'b1;
							stk_wd = var_val;
							res_d  = var_val;
						end
						OP_POP: begin
							cnt_ld = 1'b1;
							cnt_d  = cnt_m1;
							res_d  = a_q;
						end
						OP_COMPARE: begin
							cond_d = rel_hit;
							cnt_ld = 1'b1;
							cnt_d  = cnt_m3;
							stk_ra = cnt_m4[SA_W-1:0];
							res_d  = '0;
							if (cnt_q > CNT_W'(3)) begin
								res_ld  = 1'b0;
								state_d = S_TOPC;
							end
						end
						OP_CLEAR: begin
							cnt_ld = 1'b1;
							cnt_d  = '0;
							res_d  = '0;
						end
						default: begin
							res_d = top_old;
						end
					endcase
				end
			end
			S_MULDIV: begin
				if (md_stat.done) begin
					stk_we  = 1'b1;
					stk_wa  = cnt_m2[SA_W-1:0];
					stk_wd  = md_res;
					cnt_ld  = 1'b1;
					cnt_d   = cnt_m1;
					res_ld  = 1'b1;
					res_d   = md_res;
					state_d = S_DONE;
				end
			end
			S_TOPC: begin
				res_ld  = 1'b1;
				res_d   = stk_rd_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			var_vld_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_ld) begin
				cnt_q <= cnt_d;
			end
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// Clearing the variables follows any store made by the same item.
			if (var_clr) begin
				var_vld_q <= '0;
			end else if (var_we) begin
				var_vld_q[var_wa] <= 1'b1;
			end
		end
	end

	// Item and operand registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(in_op);
			val_q   <= val_ext[WORD_BITS-1:0];
			cv_q    <= in_clear_vars;
			under_q <= (cnt_q < CNT_W'(need_count(op_t'(in_op))));
		end
		if (state_q == S_RDA) begin
			a_q <= stk_rd_q;
		end
		if (state_q == S_RDB) begin
			b_q <= stk_rd_q;
		end
		if (state_q == S_RDC) begin
			c_q <= stk_rd_q;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (info_ld) begin
			cond_q <= cond_d;
			stat_q <= exec_stat;
		end
		if (out_ld) begin
			out_res_q  <= res_wide[31:0];
			out_cond_q <= cond_q;
			out_stat_q <= stat_q;
		end
	end

	assign res_wide = 64'(res_q);

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rd_q <= stk_mem[stk_ra];
	end

	// Variable store: written by store, read by index at the address on the top of stack.
	always_ff @(posedge clk) begin
		if (var_we) begin
			var_mem[var_wa] <= a_q;
		end
		var_rd_q  <= var_mem[var_ra];
		var_rdv_q <= var_vld_q[var_ra];
	end

	esu_muldiv #(
		.WORD_BITS(WORD_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (md_ctrl),
		.num    (b_q),
		.den    (a_q),
		.stat   (md_stat),
		.result (md_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_stat_q, out_cond_q, out_res_q};

	// The stack never holds more than its depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// A flagged item leaves the stack count as it was.
	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && exec_stat != ST_OK) |=> (cnt_q == $past(cnt_q)))
		else $error("flagged item changed the stack count");

	// The shared unit is only started while it is free.
	a_md_free: assert property (@(posedge clk) disable iff (!arst_n)
		md_ctrl.start |-> !md_stat.busy)
		else $error("shared unit started while busy");

	// An accepted item always begins with the first operand read.
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RDA))
		else $error("accepted item did not start its operand read");

endmodule
